### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSTAT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fstat assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSTAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fstat assertion failed");

`endif

### rtl/fstat_pkg.sv
package fstat_pkg;

  localparam int OP_W     = 2;
  localparam int TIME_W   = 32;
  localparam int RATE_W   = 16;
  localparam int POLYIN_W = 24;
  localparam int POLY_W   = 25;
  localparam int CNT_W    = 32;
  localparam int RSUM_W   = 48;
  localparam int PSUM_W   = 57;
  localparam int STAT_W   = 2;

  // dividend 2*sum+count, widest for the polygon sum
  localparam int NUM_W    = PSUM_W + 2;
  // divisor 2*count
  localparam int DVS_W    = CNT_W + 1;
  // width of the divider step counter
  localparam int DIVCNT_W = 5;

  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd1;

  localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_CMD     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_RUNNING = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

### rtl/fstat_if.sv
interface fstat_in_if import fstat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [TIME_W-1:0]   now_ms;
  logic [RATE_W-1:0]   frame_rate;
  logic [POLYIN_W-1:0] world_polys;
  logic [POLYIN_W-1:0] model_polys;

  modport source (
    output valid, op, now_ms, frame_rate, world_polys, model_polys,
    input  ready
  );
  modport sink (
    input  valid, op, now_ms, frame_rate, world_polys, model_polys,
    output ready
  );
endinterface

interface fstat_out_if import fstat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              running;
  logic [RATE_W-1:0] min_rate;
  logic [RATE_W-1:0] max_rate;
  logic [RATE_W-1:0] avg_rate;
  logic [POLY_W-1:0] min_poly;
  logic [POLY_W-1:0] max_poly;
  logic [POLY_W-1:0] avg_poly;
  logic [TIME_W-1:0] elapsed_ms;

  modport source (
    output valid, status, running, min_rate, max_rate, avg_rate,
           min_poly, max_poly, avg_poly, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, status, running, min_rate, max_rate, avg_rate,
           min_poly, max_poly, avg_poly, elapsed_ms,
    output ready
  );
endinterface

### rtl/frame_stats_monitor.sv
// Channel   Dir  Payload
// --------  ---  -------------------------------------------------------------
// cfg       in   cfg_we_i / cfg_wdata_i: duration_ms, written on enable
// in_i      in   op, now_ms, frame_rate, world_polys, model_polys
// out_o     out  status, running, min/max/avg rate, min/max/avg poly, elapsed
//
// Start, stop, ignored and all-zero samples go from idle through exec to done;
// other samples load, check and, unless the quotient overflows, divide per mean.
// The shared restoring divider gives one quotient bit per cycle, 16 steps for
// the rate mean and 25 for the polygon mean, after a load and a check each.
// Reset (rst_ni low, async) clears the run state, statistics and duration.
// in_i.ready is high only when idle; a held result stalls the next beat in done.
module frame_stats_monitor import fstat_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i,
  fstat_in_if.sink          in_i,
  fstat_out_if.source       out_o
);

  state_e state_q, state_d;

  // captured beat
  logic [OP_W-1:0]   op_q;
  logic [TIME_W-1:0] now_q;
  logic [RATE_W-1:0] rate_q;
  logic [POLY_W-1:0] poly_q;

  // run state and statistics
  logic              active_q;
  logic [TIME_W-1:0] duration_q;
  logic [TIME_W-1:0] start_q;
  logic [TIME_W-1:0] end_q;
  logic [CNT_W-1:0]  count_q;
  logic [TIME_W-1:0] elapsed_q;
  logic [RATE_W-1:0] rlow_q, rhigh_q, rmean_q;
  logic [RSUM_W-1:0] rsum_q;
  logic [POLY_W-1:0] plow_q, phigh_q, pmean_q;
  logic [PSUM_W-1:0] psum_q;
  logic [STAT_W-1:0] status_q;
  logic              need_poly_q;
  logic              sel_poly_q;

  // divider
  logic [NUM_W-1:0]    div_num_q;
  logic [DVS_W-1:0]    div_rem_q;
  logic [POLY_W-1:0]   div_low_q;
  logic [POLY_W-1:0]   div_quo_q;
  logic [DIVCNT_W-1:0] div_cnt_q;

  // output register
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic              out_running_q;
  logic [RATE_W-1:0] out_min_rate_q, out_max_rate_q, out_avg_rate_q;
  logic [POLY_W-1:0] out_min_poly_q, out_max_poly_q, out_avg_poly_q;
  logic [TIME_W-1:0] out_elapsed_q;

  // strobes
  logic accept;
  logic exec_en, load_en, check_en, step_en, mean_wr, out_load;

  // ---------------------------------------------------------------------------
  // Sample arithmetic
  logic              is_start, is_stop, smp_go;
  logic [CNT_W-1:0]  cnt_inc;
  logic [RSUM_W:0]   rsum_add;
  logic [PSUM_W:0]   psum_add;
  logic [TIME_W-1:0] gap;
  logic [TIME_W-1:0] elapsed_lim;
  logic              stop_lim;
  logic              more_poly;

  assign is_start = (op_q == OP_START);
  assign is_stop  = (op_q == OP_STOP);
  assign smp_go   = !is_start && !is_stop && active_q;
  assign cnt_inc  = (count_q == '1) ? count_q : count_q + 1'b1;
  assign rsum_add = {1'b0, rsum_q} + {{(RSUM_W + 1 - RATE_W){1'b0}}, rate_q};
  assign psum_add = {1'b0, psum_q} + {{(PSUM_W + 1 - POLY_W){1'b0}}, poly_q};
  // a late sample moves the end up to now, leaving no gap
  assign gap         = (now_q > end_q) ? '0 : end_q - now_q;
  assign elapsed_lim = (duration_q >= gap) ? duration_q - gap : '0;
  assign stop_lim    = (now_q >= end_q);
  assign more_poly   = !sel_poly_q && need_poly_q;

  // ---------------------------------------------------------------------------
  // Divider datapath
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    r0;
  logic              ovf;
  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;
  logic              ge;
  logic [POLY_W-1:0] quo_next;
  logic              div_last;
  logic [NUM_W-1:0]  num_next;

  assign dvs = {count_q, 1'b0};
  assign num_next = sel_poly_q ?
      {1'b0, psum_q, 1'b0} + {{(NUM_W - CNT_W){1'b0}}, count_q} :
      {{(NUM_W - RSUM_W - 1){1'b0}}, rsum_q, 1'b0}
        + {{(NUM_W - CNT_W){1'b0}}, count_q};
  // quotient overflows the field exactly when the top part reaches the divisor
  assign r0  = sel_poly_q ? div_num_q[NUM_W-1:POLY_W]
                          : div_num_q[RSUM_W+1:RATE_W];
  assign ovf = (r0 >= {1'b0, dvs});
  assign shifted  = {div_rem_q, div_low_q[POLY_W-1]};
  assign diff     = {1'b0, shifted} - {2'b0, dvs};
  assign ge       = !diff[DVS_W+1];
  assign quo_next = {div_quo_q[POLY_W-2:0], ge};
  assign div_last = (div_cnt_q == DIVCNT_W'(1));

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (smp_go && (rate_q != '0 || poly_q != '0)) state_d = ST_LOAD;
        else state_d = ST_DONE;
      end
      ST_LOAD: state_d = ST_CHECK;
      ST_CHECK: begin
        if (ovf) state_d = more_poly ? ST_LOAD : ST_DONE;
        else state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_last) state_d = more_poly ? ST_LOAD : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_i.ready = 1'b0;
    exec_en    = 1'b0;
    load_en    = 1'b0;
    check_en   = 1'b0;
    step_en    = 1'b0;
    mean_wr    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_i.ready = 1'b1;
      ST_EXEC:  exec_en = 1'b1;
      ST_LOAD:  load_en = 1'b1;
      ST_CHECK: begin
        check_en = 1'b1;
        mean_wr  = ovf;
      end
      ST_DIV: begin
        step_en = 1'b1;
        mean_wr = div_last;
      end
      ST_DONE:  out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Beat capture and divider working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.op;
      now_q  <= in_i.now_ms;
      rate_q <= in_i.frame_rate;
      poly_q <= {1'b0, in_i.world_polys} + {1'b0, in_i.model_polys};
    end
    if (load_en) begin
      div_num_q <= num_next;
    end
    if (check_en) begin
      div_rem_q <= r0[DVS_W-1:0];
      div_low_q <= sel_poly_q ? div_num_q[POLY_W-1:0]
                              : {div_num_q[RATE_W-1:0], {(POLY_W - RATE_W){1'b0}}};
      div_quo_q <= '0;
      div_cnt_q <= sel_poly_q ? DIVCNT_W'(POLY_W) : DIVCNT_W'(RATE_W);
    end
    if (step_en) begin
      div_rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      div_low_q <= {div_low_q[POLY_W-2:0], 1'b0};
      div_quo_q <= quo_next;
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Run state and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q  <= '0;
      active_q    <= 1'b0;
      start_q     <= '0;
      end_q       <= '0;
      count_q     <= '0;
      elapsed_q   <= '0;
      rlow_q      <= '0;
      rhigh_q     <= '0;
      rsum_q      <= '0;
      rmean_q     <= '0;
      plow_q      <= '0;
      phigh_q     <= '0;
      psum_q      <= '0;
      pmean_q     <= '0;
      status_q    <= STAT_OK;
      need_poly_q <= 1'b0;
      sel_poly_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        duration_q <= cfg_wdata_i;
      end

      if (exec_en) begin
        status_q    <= STAT_OK;
        need_poly_q <= (poly_q != '0);
        sel_poly_q  <= (rate_q == '0);
        if (is_start) begin
          if (active_q) begin
            status_q <= STAT_BAD_CMD;
          end else begin
            active_q  <= 1'b1;
            count_q   <= '0;
            elapsed_q <= '0;
            rlow_q    <= '1;
            rhigh_q   <= '0;
            rsum_q    <= '0;
            rmean_q   <= '0;
            plow_q    <= '1;
            phigh_q   <= '0;
            psum_q    <= '0;
            pmean_q   <= '0;
            start_q   <= now_q;
            end_q     <= (duration_q != '0) ? now_q + duration_q : '0;
          end
        end else if (is_stop) begin
          if (active_q) active_q <= 1'b0;
          else status_q <= STAT_BAD_CMD;
        end else if (!active_q) begin
          status_q <= STAT_NOT_RUNNING;
        end else begin
          count_q <= cnt_inc;
          if (rate_q < rlow_q) rlow_q <= rate_q;
          if (rate_q > rhigh_q) rhigh_q <= rate_q;
          if (rate_q != '0) begin
            rsum_q <= rsum_add[RSUM_W] ? '1 : rsum_add[RSUM_W-1:0];
          end
          if (poly_q < plow_q) plow_q <= poly_q;
          if (poly_q > phigh_q) phigh_q <= poly_q;
          if (poly_q != '0) begin
            psum_q <= psum_add[PSUM_W] ? '1 : psum_add[PSUM_W-1:0];
          end
          if (duration_q != '0) begin
            if (now_q > end_q) end_q <= now_q;
            elapsed_q <= elapsed_lim;
            if (stop_lim) active_q <= 1'b0;
          end else begin
            elapsed_q <= now_q - start_q;
          end
        end
      end

      if (mean_wr) begin
        if (sel_poly_q) pmean_q <= ovf && check_en ? '1 : quo_next;
        else rmean_q <= ovf && check_en ? '1 : quo_next[RATE_W-1:0];
        if (more_poly) sel_poly_q <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q   <= status_q;
      out_running_q  <= active_q;
      out_min_rate_q <= rlow_q;
      out_max_rate_q <= rhigh_q;
      out_avg_rate_q <= rmean_q;
      out_min_poly_q <= plow_q;
      out_max_poly_q <= phigh_q;
      out_avg_poly_q <= pmean_q;
      out_elapsed_q  <= elapsed_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.running    = out_running_q;
  assign out_o.min_rate   = out_min_rate_q;
  assign out_o.max_rate   = out_max_rate_q;
  assign out_o.avg_rate   = out_avg_rate_q;
  assign out_o.min_poly   = out_min_poly_q;
  assign out_o.max_poly   = out_max_poly_q;
  assign out_o.avg_poly   = out_avg_poly_q;
  assign out_o.elapsed_ms = out_elapsed_q;

endmodule

### rtl/fstat_checker.sv
`include "assert_macros.svh"

module fstat_checker import fstat_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [STAT_W-1:0] out_status_i,
  input logic              out_running_i,
  input logic [RATE_W-1:0] out_max_rate_i,
  input logic [RATE_W-1:0] out_avg_rate_i,
  input logic [POLY_W-1:0] out_max_poly_i,
  input logic [POLY_W-1:0] out_avg_poly_i,
  input logic [TIME_W-1:0] out_elapsed_i
);

  // one beat in flight: the unit is busy right after an accept
  `FSTAT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // an ignored sample only comes from an idle monitor
  `FSTAT_ASSERT_IMPL(a_ignored_not_running, clk_i, rst_ni, out_valid_i && out_status_i == STAT_NOT_RUNNING, !out_running_i)

  // a nonzero mean needs a nonzero sample in the run
  `FSTAT_ASSERT_IMPL(a_rate_mean_has_max, clk_i, rst_ni, out_valid_i && out_avg_rate_i != '0, out_max_rate_i != '0)
  `FSTAT_ASSERT_IMPL(a_poly_mean_has_max, clk_i, rst_ni, out_valid_i && out_avg_poly_i != '0, out_max_poly_i != '0)

  // stalled result holds
  `FSTAT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_elapsed_i) && $stable(out_status_i))

endmodule

bind frame_stats_monitor fstat_checker u_fstat_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_status_i   (out_o.status),
  .out_running_i  (out_o.running),
  .out_max_rate_i (out_o.max_rate),
  .out_avg_rate_i (out_o.avg_rate),
  .out_max_poly_i (out_o.max_poly),
  .out_avg_poly_i (out_o.avg_poly),
  .out_elapsed_i  (out_o.elapsed_ms)
);

### bench/frame_stats_monitor_tb.sv
`timescale 1ns / 100ps

module frame_stats_monitor_tb import fstat_pkg::*; ();

  localparam logic [OP_W-1:0] OP_SAMPLE     = 2'd2;
  localparam logic [OP_W-1:0] OP_SAMPLE_ALT = 2'd3;  // decoded like a sample

  localparam logic [63:0] RATE_SUM_MAX = {16'd0, {RSUM_W{1'b1}}};
  localparam logic [63:0] POLY_SUM_MAX = {7'd0, {PSUM_W{1'b1}}};
  localparam logic [63:0] RATE_MAX     = {48'd0, {RATE_W{1'b1}}};
  localparam logic [63:0] POLY_MAX     = {39'd0, {POLY_W{1'b1}}};

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [TIME_W-1:0]   now_ms;
    logic [RATE_W-1:0]   frame_rate;
    logic [POLYIN_W-1:0] world_polys;
    logic [POLYIN_W-1:0] model_polys;
  } perf_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              running;
    logic [RATE_W-1:0] min_rate;
    logic [RATE_W-1:0] max_rate;
    logic [RATE_W-1:0] avg_rate;
    logic [POLY_W-1:0] min_poly;
    logic [POLY_W-1:0] max_poly;
    logic [POLY_W-1:0] avg_poly;
    logic [TIME_W-1:0] elapsed_ms;
  } stats_t;

  typedef struct packed {
    logic              set_dur;
    logic [TIME_W-1:0] dur;
    perf_item_t        it;
    logic              typed;
    stats_t            want;
  } plan_row_t;

  localparam stats_t NO_CHECK = '0;
  localparam stats_t BAD_AT_RESET =
    '{STAT_BAD_CMD, 1'b0, 16'd0, 16'd0, 16'd0, 25'd0, 25'd0, 25'd0, 32'd0};
  localparam stats_t IGNORED_AT_RESET =
    '{STAT_NOT_RUNNING, 1'b0, 16'd0, 16'd0, 16'd0, 25'd0, 25'd0, 25'd0, 32'd0};
  localparam stats_t FRESH_RUN =
    '{STAT_OK, 1'b1, 16'hFFFF, 16'd0, 16'd0, 25'h1FFFFFF, 25'd0, 25'd0, 32'd0};
  localparam stats_t RESTART_REFUSED =
    '{STAT_BAD_CMD, 1'b1, 16'hFFFF, 16'd0, 16'd0, 25'h1FFFFFF, 25'd0, 25'd0, 32'd0};

  localparam int PLAN_LEN = 23;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // idle after reset: bad stop, ignored sample
    '{1'b0, 32'd0, '{OP_STOP, 32'd0, 16'd0, 24'd0, 24'd0}, 1'b1, BAD_AT_RESET},
    '{1'b0, 32'd0, '{OP_SAMPLE, 32'd5, 16'd100, 24'd7, 24'd9}, 1'b1, IGNORED_AT_RESET},
    // unlimited run
    '{1'b0, 32'd0, '{OP_START, 32'd1000, 16'd0, 24'd0, 24'd0}, 1'b1, FRESH_RUN},
    '{1'b0, 32'd0, '{OP_START, 32'd1001, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
      RESTART_REFUSED},
    '{1'b0, 32'd0, '{OP_SAMPLE, 32'd1010, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
      '{STAT_OK, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        25'h1FFFFFE, 25'h1FFFFFE, 25'h1FFFFFE, 32'd10}},
    // zero sample: joins min, leaves sums and means alone
    '{1'b0, 32'd0, '{OP_SAMPLE, 32'd1020, 16'd0, 24'd0, 24'd0}, 1'b1,
      '{STAT_OK, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF,
        25'd0, 25'h1FFFFFE, 25'h1FFFFFE, 32'd20}},
    '{1'b0, 32'd0, '{OP_SAMPLE_ALT, 32'd1030, 16'd1, 24'd1, 24'd0}, 1'b0, NO_CHECK},
    '{1'b0, 32'd0, '{OP_SAMPLE, 32'd1040, 16'h8000, 24'h800000, 24'h7FFFFF}, 1'b0,
      NO_CHECK},
    // time stamp behind the start: elapsed wraps
    '{1'b0, 32'd0, '{OP_SAMPLE, 32'd999, 16'h5555, 24'hAAAAAA, 24'h555555}, 1'b0,
      NO_CHECK},
    '{1'b0, 32'd0, '{OP_STOP, 32'd1050, 16'd0, 24'd0, 24'd0}, 1'b0, NO_CHECK},
    '{1'b0, 32'd0, '{OP_STOP, 32'd1060, 16'd0, 24'd0, 24'd0}, 1'b0, NO_CHECK},
    '{1'b0, 32'd0, '{OP_SAMPLE, 32'd1070, 16'h1234, 24'd1, 24'd1}, 1'b0, NO_CHECK},
    // limited runs; end stamp wraps past zero
    '{1'b1, 32'd100, '{OP_START, 32'hFFFFFFC0, 16'd0, 24'd0, 24'd0}, 1'b1, FRESH_RUN},
    '{1'b0, 32'd0, '{OP_SAMPLE, 32'hFFFFFFD0, 16'd60, 24'd500, 24'd20}, 1'b0, NO_CHECK},
    '{1'b0, 32'd0, '{OP_START, 32'd2000, 16'd0, 24'd0, 24'd0}, 1'b1, FRESH_RUN},
    '{1'b0, 32'd0, '{OP_SAMPLE, 32'd2040, 16'd30, 24'd100, 24'd200}, 1'b0, NO_CHECK},
    // gap wider than the duration: elapsed clamps at zero
    '{1'b0, 32'd0, '{OP_SAMPLE, 32'd1900, 16'd90, 24'd300, 24'd0}, 1'b0, NO_CHECK},
    // duration changed while running
    '{1'b1, 32'd0, '{OP_SAMPLE, 32'd2200, 16'd45, 24'd10, 24'd10}, 1'b0, NO_CHECK},
    '{1'b1, 32'hFFFFFFFF, '{OP_SAMPLE, 32'd2300, 16'd50, 24'd1, 24'd2}, 1'b0,
      NO_CHECK},
    '{1'b0, 32'd0, '{OP_START, 32'd0, 16'd0, 24'd0, 24'd0}, 1'b1, FRESH_RUN},
    '{1'b0, 32'd0, '{OP_SAMPLE, 32'hFFFFFFFF, 16'd7, 24'hFFFFFF, 24'd0}, 1'b0, NO_CHECK},
    '{1'b1, 32'd1, '{OP_START, 32'hFFFFFFFF, 16'd0, 24'd0, 24'd0}, 1'b1, FRESH_RUN},
    '{1'b0, 32'd0, '{OP_SAMPLE, 32'hFFFFFFFF, 16'hFFFF, 24'd0, 24'hFFFFFF}, 1'b0,
      NO_CHECK}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [TIME_W-1:0] cfg_wdata_i;

  fstat_in_if  in_if ();
  fstat_out_if out_if ();

  frame_stats_monitor uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // predictor state
  logic [TIME_W-1:0] run_len_ms = '0;
  logic              run_on     = 1'b0;
  logic [TIME_W-1:0] t_begin    = '0;
  logic [TIME_W-1:0] t_finish   = '0;
  logic [CNT_W-1:0]  n_upd      = '0;
  logic [RATE_W-1:0] rate_lo    = '0;
  logic [RATE_W-1:0] rate_hi    = '0;
  logic [RSUM_W-1:0] rate_acc   = '0;
  logic [RATE_W-1:0] rate_avg   = '0;
  logic [POLY_W-1:0] poly_lo    = '0;
  logic [POLY_W-1:0] poly_hi    = '0;
  logic [PSUM_W-1:0] poly_acc   = '0;
  logic [POLY_W-1:0] poly_avg   = '0;
  logic [TIME_W-1:0] el_ms      = '0;

  stats_t      stats_due_q [$];
  int unsigned stats_errors = 0;
  bit          quiet        = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned hold_left    = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("frame_stats_monitor_tb: FAIL");
    $finish;
  end

  function automatic logic [63:0] rounded_avg(logic [63:0] acc, logic [CNT_W-1:0] cnt,
                                               logic [63:0] lim);
    logic [63:0] q;
    q = ((acc << 1) + {32'd0, cnt}) / ({32'd0, cnt} << 1);
    return (q > lim) ? lim : q;
  endfunction

  function automatic stats_t predict_stats(perf_item_t it);
    stats_t            r;
    logic [POLY_W-1:0] total;
    logic [63:0]       s;
    logic [TIME_W-1:0] gap;
    total = {1'b0, it.world_polys} + {1'b0, it.model_polys};
    r.status = STAT_OK;
    if (it.op == OP_START) begin
      if (run_on) begin
        r.status = STAT_BAD_CMD;
      end else begin
        run_on   = 1'b1;
        n_upd    = '0;
        el_ms    = '0;
        rate_lo  = '1;
        rate_hi  = '0;
        rate_acc = '0;
        rate_avg = '0;
        poly_lo  = '1;
        poly_hi  = '0;
        poly_acc = '0;
        poly_avg = '0;
        t_begin  = it.now_ms;
        t_finish = (run_len_ms != 0) ? it.now_ms + run_len_ms : '0;
      end
    end else if (it.op == OP_STOP) begin
      if (run_on) run_on = 1'b0;
      else r.status = STAT_BAD_CMD;
    end else if (!run_on) begin
      r.status = STAT_NOT_RUNNING;
    end else begin
      if (n_upd != '1) n_upd = n_upd + 1'b1;
      if (it.frame_rate < rate_lo) rate_lo = it.frame_rate;
      if (it.frame_rate > rate_hi) rate_hi = it.frame_rate;
      if (it.frame_rate != 0) begin
        s = {16'd0, rate_acc} + {48'd0, it.frame_rate};
        rate_acc = (s > RATE_SUM_MAX) ? RATE_SUM_MAX[RSUM_W-1:0] : s[RSUM_W-1:0];
        rate_avg = RATE_W'(rounded_avg({16'd0, rate_acc}, n_upd, RATE_MAX));
      end
      if (total < poly_lo) poly_lo = total;
      if (total > poly_hi) poly_hi = total;
      if (total != 0) begin
        s = {7'd0, poly_acc} + {39'd0, total};
        poly_acc = (s > POLY_SUM_MAX) ? POLY_SUM_MAX[PSUM_W-1:0] : s[PSUM_W-1:0];
        poly_avg = POLY_W'(rounded_avg({7'd0, poly_acc}, n_upd, POLY_MAX));
      end
      if (run_len_ms != 0) begin
        if (it.now_ms > t_finish) t_finish = it.now_ms;
        gap   = t_finish - it.now_ms;
        el_ms = (run_len_ms >= gap) ? run_len_ms - gap : '0;
        if (it.now_ms >= t_finish) run_on = 1'b0;
      end else begin
        el_ms = it.now_ms - t_begin;
      end
    end
    r.running    = run_on;
    r.min_rate   = rate_lo;
    r.max_rate   = rate_hi;
    r.avg_rate   = rate_avg;
    r.min_poly   = poly_lo;
    r.max_poly   = poly_hi;
    r.avg_poly   = poly_avg;
    r.elapsed_ms = el_ms;
    return r;
  endfunction

  function automatic perf_item_t make_item(logic [OP_W-1:0] op, logic [TIME_W-1:0] now);
    perf_item_t  it;
    int unsigned pick;
    it.op     = op;
    it.now_ms = now;
    pick = $urandom_range(0, 9);
    if (pick == 0)     it.frame_rate = '0;
    else if (pick == 1) it.frame_rate = '1;
    else if (pick < 6) it.frame_rate = RATE_W'($urandom());
    else               it.frame_rate = RATE_W'($urandom_range(20, 200));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      it.world_polys = '0;
      it.model_polys = '0;
    end else if (pick == 1) begin
      it.world_polys = '1;
      it.model_polys = '1;
    end else if (pick < 6) begin
      it.world_polys = POLYIN_W'($urandom());
      it.model_polys = POLYIN_W'($urandom());
    end else begin
      it.world_polys = POLYIN_W'($urandom_range(0, 50000));
      it.model_polys = POLYIN_W'($urandom_range(0, 20000));
    end
    return it;
  endfunction

  // offer one beat from a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input perf_item_t it, input logic typed, input stats_t want,
                           output logic [STAT_W-1:0] st);
    stats_t pred;
    while (!quiet && $urandom_range(0, 99) < 38) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= it.op;
    in_if.now_ms      <= it.now_ms;
    in_if.frame_rate  <= it.frame_rate;
    in_if.world_polys <= it.world_polys;
    in_if.model_polys <= it.model_polys;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pred = predict_stats(it);
    stats_due_q.push_back(typed ? want : pred);
    st = pred.status;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (stats_due_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_duration(input logic [TIME_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    run_len_ms = v;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial out_if.ready = 1'b0;
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = 400;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet || ($urandom_range(0, 99) >= 38);
    end
  end

  always @(posedge clk_i) begin : check_results
    stats_t got;
    stats_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.status, out_if.running, out_if.min_rate, out_if.max_rate,
              out_if.avg_rate, out_if.min_poly, out_if.max_poly, out_if.avg_poly,
              out_if.elapsed_ms};
      if (stats_due_q.size() == 0) begin
        stats_errors++;
        if (stats_errors <= 10) $display("%0t: result beat with none pending: %p", $time, got);
      end else begin
        want = stats_due_q.pop_front();
        if (got.status !== want.status || got.running !== want.running ||
            got.min_rate !== want.min_rate || got.max_rate !== want.max_rate ||
            got.avg_rate !== want.avg_rate || got.min_poly !== want.min_poly ||
            got.max_poly !== want.max_poly || got.avg_poly !== want.avg_poly ||
            got.elapsed_ms !== want.elapsed_ms) begin
          stats_errors++;
          if (stats_errors <= 10) begin
            $display("%0t: stats mismatch", $time);
            $display("  want %p", want);
            $display("  got  %p", got);
          end
        end
      end
    end
  end

  initial begin
    perf_item_t        it;
    logic [STAT_W-1:0] st;
    logic [TIME_W-1:0] dur;
    int unsigned       max_step;
    int unsigned       ok_items;
    int unsigned       iter;
    int unsigned       roll;
    int unsigned       waited;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.op          = OP_START;
    in_if.now_ms      = '0;
    in_if.frame_rate  = '0;
    in_if.world_polys = '0;
    in_if.model_polys = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].set_dur) begin
        drain_results();
        write_duration(PLAN[i].dur);
      end
      send_item(PLAN[i].it, PLAN[i].typed, PLAN[i].want, st);
    end

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1:       dur = 32'd40;
        2:       dur = 32'd1;
        4:       dur = 32'd250000;
        5:       dur = '1;
        6:       dur = $urandom_range(2, 5000);
        default: dur = '0;
      endcase
      drain_results();  // sender holds off until every result is back
      write_duration(dur);
      quiet    = (phase == 3);
      max_step = (dur == 0) ? 300 : dur / 6 + 1;
      ok_items = 0;
      iter     = 0;
      while (ok_items < 220) begin
        iter++;
        if (phase == 1 && iter == 60) hold_off_req = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          it = make_item(OP_W'($urandom_range(0, 3)),
                         $urandom_range(0, 1) ? $urandom() : clock_ms);
        end else if (!run_on) begin
          it = make_item(OP_START, clock_ms);
        end else if (roll < 16) begin
          it = make_item(OP_STOP, clock_ms);
        end else begin
          if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
          else clock_ms = clock_ms + $urandom_range(0, max_step);
          it = make_item(($urandom_range(0, 9) == 0) ? OP_SAMPLE_ALT : OP_SAMPLE, clock_ms);
        end
        send_item(it, 1'b0, NO_CHECK, st);
        if (st == STAT_OK) ok_items++;
      end
    end
    quiet = 1'b0;

    in_if.valid <= 1'b0;
    waited = 0;
    while (stats_due_q.size() != 0 && waited < 50000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (60) @(negedge clk_i);
    if (stats_due_q.size() != 0) stats_errors++;

    if (stats_errors == 0) begin
      $display("frame_stats_monitor_tb: PASS");
    end else begin
      $display("frame_stats_monitor_tb: FAIL");
    end
    $finish;
  end

endmodule

### frame_stats_monitor.f
+incdir+rtl
rtl/fstat_pkg.sv
rtl/fstat_if.sv
rtl/frame_stats_monitor.sv
rtl/fstat_checker.sv
bench/frame_stats_monitor_tb.sv
